// ----- hdl/lzw_byte_compressor_top_defines.svh -----
// assertion macros for the lzw byte compressor
// used by lzw_byte_compressor_top only
`ifndef LZW_BYTE_COMPRESSOR_TOP_DEFINES_SVH
`define LZW_BYTE_COMPRESSOR_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define LZW_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);
// implication checked in the cycle after the condition
`define LZW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);
`endif

// ----- hdl/lzwc_pkg.sv -----
// shared types and constants for the lzw byte compressor
// no dependencies
package lzwc_pkg;
   localparam int HashSlots  = 8192;
   localparam int MaxCodes   = 4096;
   localparam int SlotAw     = $clog2(HashSlots);
   localparam int SlotW      = 33;
   localparam logic [11:0] CodeReset = 12'd4095;
   localparam logic [11:0] CodeEnd   = 12'd4094;
   localparam logic [12:0] FirstFree = 13'd256;
   localparam logic [12:0] MaxFree   = (MaxCodes < 4094) ? 13'(MaxCodes) : 13'd4094;

   // emit request from the sequencer to the bit packer
   typedef struct packed {
      logic        code_req;
      logic        pad_req;
      logic [11:0] code;
      logic [3:0]  width;
      logic        last;
   } pack_cmd_type;

   // packer status to the sequencer
   typedef struct packed {
      logic busy;
   } pack_sts_type;

   // home slot of a 20-bit key
   function automatic logic [SlotAw-1:0] slot_home(input logic [19:0] key);
      logic [31:0] k;
      k = {12'd0, key};
      return SlotAw'((k ^ (k >> 7) ^ (k >> 13)) % HashSlots);
   endfunction
endpackage

// ----- hdl/lzw_byte_compressor_top.sv -----
// LZW byte compressor with 9 to 12 bit codes, packed msb first
// Channels: req_ (in_byte, end_of_stream) and rsp_ (out_byte, final_byte),
// both valid/ready; a transaction moves on valid and ready high together.
// Each byte: a home-slot lookup in a 8192 x 33 single-port hash ram,
// one read per probe, stepping through address, read and compare states,
// with a further read and compare per extra probe; the ram port sets the pace.
// The bit packer drains one output byte per cycle while the receiver takes
// them, and a new byte is taken only when fewer than 8 bits wait and the
// output register is empty.
// After reset, and after every dictionary-full reset code, a clearing pass
// writes all 8192 slots, one per cycle, with req_ready low.
// On end_of_stream the block flushes the code, pads, sends end code 4094,
// pads, marks the last byte with final_byte, then clears.
// When the receiver stalls, the held byte waits in the output register and
// the sequencer stops at its next emit step; no byte is lost.
// Reset is synchronous and active high.
`include "lzw_byte_compressor_top_defines.svh"
module lzw_byte_compressor_top
   import lzwc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_final_byte
);
   pack_cmd_type cmd;
   pack_sts_type sts;

   lzwc_seq u_seq (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .req_in_byte (req_in_byte), .req_end_of_stream (req_end_of_stream),
      .cmd (cmd), .sts (sts)
   );

   lzwc_packer u_packer (
      .clock (clock), .reset (reset), .cmd (cmd), .sts (sts),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .rsp_out_byte (rsp_out_byte), .rsp_final_byte (rsp_final_byte)
   );

   // checks
   `LZW_ASSERT_IMP(a_no_dual_cmd, clock, reset, cmd.code_req, !cmd.pad_req,
      "code and pad requested together")
   `LZW_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !sts.busy,
      "input taken while packer busy")
   `LZW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_out_byte) && $stable(rsp_final_byte),
      "output transaction changed while stalled")
endmodule

// ----- hdl/lzwc_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module lzwc_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_ff <= mem_ff[addr];
   end
   assign rd_data = rd_ff;
endmodule

// ----- hdl/lzwc_packer.sv -----
// bit packer: shifts codes out msb first, one byte per transaction
// depends on lzwc_pkg
module lzwc_packer
   import lzwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  pack_cmd_type cmd,
   output pack_sts_type sts,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_final_byte
);
   logic [18:0] acc_ff, acc_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic        pad_ff, pad_in;
   logic        ov_ff, ov_in;
   logic [7:0]  ob_ff, ob_in;
   logic        of_ff, of_in;
   logic [4:0]  sh;
   logic [18:0] shifted;
   logic        take;

   assign take = ~ov_ff | rsp_ready;
   assign sh   = cnt_ff - 5'd8;
   assign shifted = acc_ff >> sh;

   // accumulate and drain one byte per cycle while the output register is free or taken
   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      pad_in  = pad_ff;
      ov_in   = ov_ff & ~rsp_ready;
      ob_in   = ob_ff;
      of_in   = of_ff;
      if (cmd.code_req) begin
         acc_in  = (acc_ff << cmd.width) | 19'({7'd0, cmd.code} & ((19'd1 << cmd.width) - 19'd1));
         cnt_in  = cnt_ff + 5'(cmd.width);
         last_in = 1'b0;
      end else if (cmd.pad_req) begin
         pad_in  = 1'b1;
         last_in = cmd.last;
      end else if (take && cnt_ff >= 5'd8) begin
         ob_in  = shifted[7:0];
         of_in  = 1'b0;
         ov_in  = 1'b1;
         cnt_in = sh;
         acc_in = acc_ff & ((19'd1 << sh) - 19'd1);
      end else if (take && pad_ff) begin
         pad_in = 1'b0;
         if (cnt_ff != 5'd0) begin
            ob_in  = 8'(acc_ff << (5'd8 - cnt_ff));
            of_in  = last_ff;
            ov_in  = 1'b1;
            cnt_in = 5'd0;
            acc_in = 19'd0;
         end else if (last_ff) begin
            of_in = 1'b1;
         end
         last_in = 1'b0;
      end
   end

   // packer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         last_ff <= 1'b0;
         pad_ff  <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
         pad_ff  <= pad_in;
         ov_ff   <= ov_in;
      end
      ob_ff <= ob_in;
      of_ff <= of_in;
   end

   assign sts.busy      = ov_ff | pad_ff | (cnt_ff >= 5'd8);
   assign rsp_valid     = ov_ff;
   assign rsp_out_byte  = ob_ff;
   assign rsp_final_byte = of_ff;
endmodule

// ----- hdl/lzwc_seq.sv -----
// sequencer: dictionary probe, insert, clear sweep and emit requests
// depends on lzwc_pkg and lzwc_ram
module lzwc_seq
   import lzwc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_in_byte,
   input  logic         req_end_of_stream,
   output pack_cmd_type cmd,
   input  pack_sts_type sts
);
   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_ADDR  = 10'b0000000100,
      S_READ  = 10'b0000001000,
      S_CMP   = 10'b0000010000,
      S_FULL  = 10'b0000100000,
      S_RST   = 10'b0001000000,
      S_ENDC  = 10'b0010000000,
      S_ENDM  = 10'b0100000000,
      S_DRAIN = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [SlotAw-1:0] idx_ff, idx_in;
   logic [SlotAw:0]  sweep_ff, sweep_in;
   logic [11:0]      cur_ff, cur_in;
   logic             have_ff, have_in;
   logic [12:0]      nfc_ff, nfc_in;
   logic [3:0]       cw_ff, cw_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             eos_ff, eos_in;
   logic             wr_en;
   logic [SlotAw-1:0] addr;
   logic [SlotW-1:0] wr_data, rd_data;
   logic [19:0]      key;

   assign key = {cur_ff, byte_ff};

   lzwc_ram #(.Width(SlotW), .Depth(HashSlots)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .addr    (addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // control sequence
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      sweep_in = sweep_ff;
      cur_in   = cur_ff;
      have_in  = have_ff;
      nfc_in   = nfc_ff;
      cw_in    = cw_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      eos_in   = eos_ff;
      wr_en    = 1'b0;
      addr     = idx_ff;
      wr_data  = '0;
      cmd      = '0;
      cmd.width = cw_ff;
      cmd.code  = cur_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            addr  = sweep_ff[SlotAw-1:0];
            sweep_in = sweep_ff + (SlotAw+1)'(1);
            if (sweep_ff == (SlotAw+1)'(HashSlots - 1)) begin
               // a pending end of stream continues with the final code
               eos_in   = 1'b0;
               state_in = eos_ff ? S_ENDC : S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = ~sts.busy;
            if (req_valid && !sts.busy) begin
               byte_in = req_in_byte;
               last_in = req_end_of_stream;
               if (!have_ff) begin
                  cur_in  = {4'd0, req_in_byte};
                  have_in = 1'b1;
                  state_in = req_end_of_stream ? S_ENDC : S_IDLE;
               end else begin
                  state_in = S_ADDR;
               end
            end
         end
         S_ADDR: begin
            idx_in   = slot_home(key);
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (!rd_data[32]) begin
               cmd.code_req = 1'b1;
               cur_in = {4'd0, byte_ff};
               if (nfc_ff < MaxFree) begin
                  wr_en   = 1'b1;
                  wr_data = {1'b1, key, nfc_ff[11:0]};
                  nfc_in  = nfc_ff + 13'd1;
                  if (nfc_ff + 13'd1 == 13'd512) cw_in = 4'd10;
                  else if (nfc_ff + 13'd1 == 13'd1024) cw_in = 4'd11;
                  else if (nfc_ff + 13'd1 == 13'd2048) cw_in = 4'd12;
                  state_in = last_ff ? S_ENDC : S_IDLE;
               end else begin
                  state_in = S_FULL;
               end
            end else if (rd_data[31:12] == key) begin
               cur_in   = rd_data[11:0];
               state_in = last_ff ? S_ENDC : S_IDLE;
            end else begin
               idx_in   = idx_ff + SlotAw'(1);
               state_in = S_READ;
            end
         end
         S_FULL: begin
            cmd.pad_req = 1'b1;
            state_in = S_RST;
         end
         S_RST: begin
            if (!sts.busy) begin
               cmd.code_req = 1'b1;
               cmd.code  = CodeReset;
               cmd.width = 4'd12;
               nfc_in   = FirstFree;
               cw_in    = 4'd9;
               sweep_in = '0;
               eos_in   = last_ff;
               state_in = S_CLEAR;
            end
         end
         S_ENDC: begin
            // wait until the packer has room for one more code
            if (!sts.busy) begin
               cmd.code_req = 1'b1;
               state_in = S_ENDM;
            end
         end
         S_ENDM: begin
            if (!sts.busy) begin
               if (eos_ff) begin
                  cmd.pad_req = 1'b1;
                  cmd.last    = 1'b1;
                  eos_in   = 1'b0;
                  have_in  = 1'b0;
                  cur_in   = '0;
                  nfc_in   = FirstFree;
                  cw_in    = 4'd9;
                  sweep_in = '0;
                  state_in = S_DRAIN;
               end else begin
                  cmd.pad_req = 1'b1;
                  eos_in   = 1'b1;
                  state_in = S_DRAIN;
               end
            end
         end
         S_DRAIN: begin
            if (!sts.busy) begin
               if (eos_ff) begin
                  cmd.code_req = 1'b1;
                  cmd.code  = CodeEnd;
                  cmd.width = 4'd12;
                  state_in = S_ENDM;
               end else begin
                  state_in = S_CLEAR;
               end
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         sweep_ff <= '0;
         have_ff  <= 1'b0;
         cur_ff   <= '0;
         nfc_ff   <= FirstFree;
         cw_ff    <= 4'd9;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         have_ff  <= have_in;
         cur_ff   <= cur_in;
         nfc_ff   <= nfc_in;
         cw_ff    <= cw_in;
         eos_ff   <= eos_in;
      end
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end
endmodule
